[design/kvat_pkg.sv]
// kvat_pkg: shared types, codes and sizes for the key/value accumulate table
// used by every module of the block but kvat_ram; no dependencies
`default_nettype none

package kvat_pkg;

    // field widths of the stream beats
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // default table size
    localparam int CAPACITY_DEF = 16;

    // packed beat widths, padded to whole bytes
    localparam int IN_FIELDS_W  = CMD_W + KEY_W + VALUE_W;
    localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + COUNT_OUT_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_code_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_MISSING = 2'd1,
        STS_FULL    = 2'd2
    } status_code_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // capture the request beat
        logic match;   // compare keys, read value memory
        logic commit;  // update table, load result register
    } dp_ctl_t;

endpackage : kvat_pkg

`default_nettype wire

[design/kvat_ram.sv]
// kvat_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module kvat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : kvat_ram

`default_nettype wire

[design/kvat_ctrl.sv]
// kvat_ctrl: request sequencer and stream handshake for the key/value table
// depends on kvat_pkg
`default_nettype none

module kvat_ctrl
    import kvat_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output dp_ctl_t   ctl
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // result register can take a new beat
    assign out_free = !out_valid_reg || m_tready;

    // handshake and datapath commands
    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_MATCH: s_tready = 1'b0;
            ST_WRITE: s_tready = out_free;
            default:  s_tready = 1'b0;
        endcase
    end

    assign ctl.load   = s_tvalid && s_tready;
    assign ctl.match  = (state_reg == ST_MATCH);
    assign ctl.commit = (state_reg == ST_WRITE) && out_free;
    assign m_tvalid   = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.load)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (ctl.commit)
                begin
                    state_next = ctl.load ? ST_MATCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb
    begin
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // no new beat while keys are being compared
    a_no_accept_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |-> !s_tready)
        else $error("request accepted during key compare");

    // a commit always leaves a result beat pending
    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid_reg)
        else $error("commit did not raise result valid");

    // table update stage is only reached from the compare stage or itself
    a_write_follows_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |->
            ($past(state_reg) == ST_MATCH || $past(state_reg) == ST_WRITE))
        else $error("update stage entered without compare");

endmodule : kvat_ctrl

`default_nettype wire

[design/kvat_datapath.sv]
// kvat_datapath: key compare array, valid bits, live count, value memory
// and result register; depends on kvat_pkg and kvat_ram
`default_nettype none

module kvat_datapath
    import kvat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_ctl_t                    ctl,
    input  wire logic      [CMD_W-1:0]      command,
    input  wire logic      [KEY_W-1:0]      key,
    input  wire logic      [VALUE_W-1:0]    value_in,
    output logic           [STATUS_W-1:0]   status,
    output logic           [VALUE_W-1:0]    value_out,
    output logic           [COUNT_OUT_W-1:0] entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request registers
    cmd_code_t          cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] val_reg;

    // table state
    logic [KEY_W-1:0]    keys_reg [CAPACITY];
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    // compare stage results
    logic                hit, hit_reg;
    logic [IDX_W-1:0]    hit_idx, hit_idx_reg;
    logic [IDX_W-1:0]    free_idx, free_idx_reg;
    logic                full, full_reg;

    // update stage
    logic [VALUE_W-1:0]  rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                add_new;
    status_code_t        status_next;
    logic [VALUE_W-1:0]  value_out_next;

    // result registers
    logic [STATUS_W-1:0]    status_reg;
    logic [VALUE_W-1:0]     value_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;

    // capture request beat
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd_code_t'(command);
            key_reg <= key;
            val_reg <= value_in;
        end
    end

    // parallel key compare; a key lives in at most one entry
    always_comb
    begin
        hit_idx = '0;
        hit     = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (valid_reg[i] && (keys_reg[i] == key_reg))
            begin
                hit     = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // lowest free entry
    always_comb
    begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign full = &valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.match)
        begin
            hit_reg      <= hit;
            hit_idx_reg  <= hit_idx;
            free_idx_reg <= free_idx;
            full_reg     <= full;
        end
    end

    // value memory, read at the hit entry during compare
    kvat_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.match),
        .rd_addr (hit_idx),
        .rd_data (rd_data)
    );

    // table update and result
    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = hit_reg ? hit_idx_reg : free_idx_reg;
        wr_data        = val_reg;
        add_new        = 1'b0;
        valid_next     = valid_reg;
        count_next     = count_reg;
        status_next    = STS_OK;
        value_out_next = '0;
        case (cmd_reg)
            CMD_INSERT, CMD_ACCUM:
            begin
                if (hit_reg)
                begin
                    wr_en = ctl.commit;
                    if (cmd_reg == CMD_ACCUM)
                    begin
                        wr_data = rd_data + val_reg;
                    end
                end
                else if (full_reg)
                begin
                    status_next = STS_FULL;
                end
                else
                begin
                    wr_en                    = ctl.commit;
                    add_new                  = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                end
            end
            CMD_LOOKUP:
            begin
                if (hit_reg)
                begin
                    value_out_next = rd_data;
                end
                else
                begin
                    status_next = STS_MISSING;
                end
            end
            default:
            begin
                if (hit_reg)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    count_next              = count_reg - CNT_W'(1);
                end
            end
        endcase
    end

    // key array, written only when an entry is allocated
    always_ff @(posedge clk)
    begin
        if (ctl.commit && add_new)
        begin
            keys_reg[free_idx_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (ctl.commit)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            count_out_reg <= COUNT_OUT_W'(count_next);
        end
    end

    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_out_reg;

    // live count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("live count disagrees with valid bits");

    // count never exceeds table size
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("live count above capacity");

    // table full is only reported with every entry in use
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(ctl.commit) && (status_reg == STS_FULL)) |-> (&valid_reg))
        else $error("table full reported with a free entry");

endmodule : kvat_datapath

`default_nettype wire

[design/key_value_accumulate_table.sv]
// key_value_accumulate_table: bounded key/value table with insert, accumulate,
// lookup and remove; one result beat per request beat.
// result: beat valid after the key compare stage and the update stage; the update
// waits while the previous result beat is still held. A new request is taken during
// the read-modify-write on the value memory, but not during the key compare
// reset: all entries invalid and live count zero at once; no clearing pass
`default_nettype none

module key_value_accumulate_table
    import kvat_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // command, key, value_in, zero pad
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata    // status, value_out, entry_count, zero pad
);

    localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    dp_ctl_t                ctl;
    logic [STATUS_W-1:0]    status;
    logic [VALUE_W-1:0]     value_out;
    logic [COUNT_OUT_W-1:0] entry_count;

    // sequencer
    kvat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    // table datapath
    kvat_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (s_tdata[CMD_W-1:0]),
        .key         (s_tdata[CMD_W+KEY_W-1:CMD_W]),
        .value_in    (s_tdata[IN_FIELDS_W-1:CMD_W+KEY_W]),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    // pack result beat
    assign m_tdata = {{OUT_PAD_W{1'b0}}, entry_count, value_out, status};

endmodule : key_value_accumulate_table

`default_nettype wire

[tb/key_value_accumulate_table_tb.sv]
// key_value_accumulate_table_tb: self-checking bench for the key/value accumulate table
// drives request beats, predicts every result beat with a local table copy and compares
// depends on kvat_pkg and key_value_accumulate_table
`default_nettype none

module key_value_accumulate_table_tb
    import kvat_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS  = CAPACITY_DEF;
    localparam int KEY_POOL_N   = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // expected contents of one result beat
    typedef struct {
        status_code_t           status;
        logic [VALUE_W-1:0]     value_out;
        logic [COUNT_OUT_W-1:0] entry_count;
    } table_result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // local copy of the table
    logic               slot_used  [TABLE_SLOTS];
    logic [KEY_W-1:0]   slot_key   [TABLE_SLOTS];
    logic [VALUE_W-1:0] slot_value [TABLE_SLOTS];
    int                 live_entries;

    table_result_t      pending_results[$];
    logic [KEY_W-1:0]   key_pool[KEY_POOL_N];
    int                 error_count    = 0;
    int unsigned        cycle_count    = 0;
    int                 sender_idle_pct = 0;
    int                 recv_stall_pct  = 0;

    key_value_accumulate_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // update the table copy for one request and return the result it gives
    function automatic table_result_t apply_request(input cmd_code_t cmd,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [VALUE_W-1:0] value);
        table_result_t res;
        int hit;
        int free_slot;
        res.status    = STS_OK;
        res.value_out = '0;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_key[i] == key)
                hit = i;
            if (free_slot < 0 && !slot_used[i])
                free_slot = i;
        end
        case (cmd)
            CMD_INSERT, CMD_ACCUM:
            begin
                if (hit >= 0)
                begin
                    if (cmd == CMD_INSERT)
                        slot_value[hit] = value;
                    else
                        slot_value[hit] = slot_value[hit] + value;
                end
                else if (free_slot < 0)
                    res.status = STS_FULL;
                else
                begin
                    slot_used[free_slot]  = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_value[free_slot] = value;
                    live_entries++;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit >= 0)
                    res.value_out = slot_value[hit];
                else
                    res.status = STS_MISSING;
            end
            default:
            begin
                // remove of an absent key is still a success
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    live_entries--;
                end
            end
        endcase
        res.entry_count = COUNT_OUT_W'(live_entries);
        return res;
    endfunction

    // predict on each accepted request beat, check each accepted result beat
    always @(posedge clk)
    begin
        table_result_t      exp_res;
        logic [STATUS_W-1:0] got_status;
        logic [VALUE_W-1:0]  got_value;
        logic [COUNT_OUT_W-1:0] got_count;
        if (rst_n && s_tvalid && s_tready)
            pending_results.push_back(apply_request(cmd_code_t'(s_tdata[CMD_W-1:0]),
                                                    s_tdata[CMD_W +: KEY_W],
                                                    s_tdata[CMD_W+KEY_W +: VALUE_W]));
        if (rst_n && m_tvalid && m_tready)
        begin
            got_status = m_tdata[STATUS_W-1:0];
            got_value  = m_tdata[STATUS_W +: VALUE_W];
            got_count  = m_tdata[STATUS_W+VALUE_W +: COUNT_OUT_W];
            if (pending_results.size() == 0)
            begin
                $display("%t unexpected result beat: status %0d value %h count %0d",
                         $realtime, got_status, got_value, got_count);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got_status !== exp_res.status)
                begin
                    $display("%t status: expected %0d actual %0d",
                             $realtime, exp_res.status, got_status);
                    error_count++;
                end
                if (got_value !== exp_res.value_out)
                begin
                    $display("%t value_out: expected %h actual %h",
                             $realtime, exp_res.value_out, got_value);
                    error_count++;
                end
                if (got_count !== exp_res.entry_count)
                begin
                    $display("%t entry_count: expected %0d actual %0d",
                             $realtime, exp_res.entry_count, got_count);
                    error_count++;
                end
            end
        end
    end

    // send one request beat, with random idle cycles ahead of it
    task automatic send_request(input cmd_code_t cmd, input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        logic [IN_TDATA_W-1:0] beat;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        beat = '0;
        beat[CMD_W-1:0]                = cmd;
        beat[CMD_W +: KEY_W]           = key;
        beat[CMD_W+KEY_W +: VALUE_W]   = value;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off requests until every expected result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_lookup();
        send_request(CMD_LOOKUP, 32'h0000_0000, $urandom());
    endtask

    task automatic test_insert_overwrite();
        send_request(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_request(CMD_LOOKUP, 32'h0000_0000, $urandom());
        send_request(CMD_LOOKUP, 32'hFFFF_FFFF, $urandom());
    endtask

    // new entry through accumulate, then an add that wraps
    task automatic test_accumulate_wrap();
        send_request(CMD_ACCUM, 32'h0000_0005, 32'hFFFF_FFFF);
        send_request(CMD_ACCUM, 32'h0000_0005, 32'h0000_0002);
        send_request(CMD_LOOKUP, 32'h0000_0005, $urandom());
    endtask

    // fill the free slots with one-hot keys, then overflow both ways
    task automatic test_table_full();
        for (int i = 0; i < TABLE_SLOTS - 3; i++)
            send_request(CMD_INSERT, 32'h1 << i, $urandom());
        send_request(CMD_INSERT, 32'hA5A5_5A5A, $urandom());
        send_request(CMD_ACCUM, 32'h5A5A_A5A5, $urandom());
    endtask

    task automatic test_remove();
        wait_for_results();
        send_request(CMD_REMOVE, 32'h0000_0005, $urandom());
        send_request(CMD_REMOVE, 32'h0000_0005, $urandom());
    endtask

    function automatic cmd_code_t pick_command(input bit filling);
        int roll;
        roll = $urandom_range(99);
        if (filling)
            return (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_ACCUM :
                   (roll < 85) ? CMD_LOOKUP : CMD_REMOVE;
        return (roll < 15) ? CMD_INSERT : (roll < 25) ? CMD_ACCUM :
               (roll < 50) ? CMD_LOOKUP : CMD_REMOVE;
    endfunction

    // mostly keys from a pool larger than the table, some one bit off, some fresh
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return key_pool[$urandom_range(KEY_POOL_N-1)];
        if (roll < 95)
            return key_pool[$urandom_range(KEY_POOL_N-1)] ^ (32'h1 << $urandom_range(KEY_W-1));
        return $urandom();
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0, 1:    return '0;
            2, 3:    return '1;
            4:       return VALUE_W'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    // random traffic that swings the table between filling and draining
    task automatic run_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
        bit filling;
        int run_left;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        filling  = 1'b1;
        run_left = $urandom_range(60, 20);
        for (int n = 0; n < count; n++)
        begin
            if (run_left == 0)
            begin
                filling  = !filling;
                run_left = $urandom_range(60, 20);
            end
            run_left--;
            send_request(pick_command(filling), pick_key(), pick_value());
        end
        wait_for_results();
    endtask

    // test sequence
    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
        end
        live_entries = 0;
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : $urandom();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookup();
        test_insert_overwrite();
        test_accumulate_wrap();
        test_table_full();
        test_remove();
        run_random_traffic(406, 0, 0);
        run_random_traffic(406, 54, 0);
        run_random_traffic(406, 0, 54);
        run_random_traffic(406, 36, 36);

        // let any late beat show up before the verdict
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule : key_value_accumulate_table_tb

`default_nettype wire
